### hdl/smv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types and constants for the stun message validator.
// ----------------------------------------------------------------------------
package smv_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 152;

  localparam int unsigned POS_W   = 17;
  localparam int unsigned HDR_W   = 18;
  localparam int unsigned COUNT_W = 14;

  localparam logic [31:0]        MAGIC_COOKIE   = 32'h2112_A442;
  localparam logic [15:0]        CLASS_BITS     = 16'h0110;
  localparam logic [15:0]        METHOD_BINDING = 16'h0001;
  localparam logic [POS_W-1:0]   HEADER_BYTES   = 17'd20;
  localparam logic [HDR_W-1:0]   FIRST_ATTR_POS = 18'd20;
  localparam logic [POS_W-1:0]   POS_MAX        = 17'h1_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 14'h3FFF;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_SHORT      = 3'd1,
    ERR_START_BITS = 3'd2,
    ERR_MAGIC      = 3'd3,
    ERR_UNALIGNED  = 3'd4,
    ERR_SIZE       = 3'd5,
    ERR_METHOD     = 3'd6,
    ERR_OVERRUN    = 3'd7
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    err_t               error_code;
    logic [15:0]        message_type;
    logic [1:0]         message_class;
    logic               response_flag;
    logic [15:0]        msg_length;
    logic [31:0]        transaction_id_high;
    logic [63:0]        transaction_id_low;
    logic [COUNT_W-1:0] attribute_count;
  } result_t;

endpackage

### hdl/smv_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_in_reg
// Input register stage holding one datagram byte and its last mark.
// ----------------------------------------------------------------------------
module smv_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  smv_pkg::item_t in_item,
  output logic           st_valid,
  input  logic           st_take,
  output smv_pkg::item_t st_item
);
  import smv_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready = !valid_r || st_take;
  assign st_valid = valid_r;
  assign st_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### hdl/smv_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_walk
// Header capture, attribute walk, verdict: one byte a cycle, last on res_free.
// ----------------------------------------------------------------------------
module smv_walk (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             st_valid,
  input  smv_pkg::item_t   st_item,
  output logic             st_take,
  input  logic             res_free,
  output logic             res_valid,
  output smv_pkg::result_t res
);
  import smv_pkg::*;

  logic [POS_W-1:0]   pos_r,    pos_nxt;
  logic [15:0]        type_r,   type_nxt;
  logic [15:0]        len_r,    len_nxt;
  logic [31:0]        cookie_r, cookie_nxt;
  logic [31:0]        tidu_r,   tidu_nxt;
  logic [63:0]        tidl_r,   tidl_nxt;
  logic [HDR_W-1:0]   nhp_r,    nhp_nxt;
  logic [15:0]        alc_r,    alc_nxt;
  logic [HDR_W-1:0]   lve_r,    lve_nxt;
  logic [COUNT_W-1:0] cnt_r,    cnt_nxt;

  logic [7:0]       b;
  logic [HDR_W:0]   pos_ext;
  logic [HDR_W:0]   hdr2;
  logic [HDR_W:0]   hdr3;
  logic [15:0]      attr_len;
  logic [16:0]      padded;
  logic [POS_W-1:0] size_need;
  err_t             verdict;

  assign b        = st_item.data_byte;
  assign pos_ext  = {2'b00, pos_r};
  assign hdr2     = {1'b0, nhp_r} + 19'd2;
  assign hdr3     = {1'b0, nhp_r} + 19'd3;
  assign attr_len = alc_r | {8'h00, b};
  assign padded   = ({1'b0, attr_len} + 17'd3) & 17'h1_FFFC;

  assign st_take   = st_valid && (!st_item.last || res_free);
  assign res_valid = st_take && st_item.last;

  // capture of one byte into the header fields or the attribute walk
  always_comb begin
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    cookie_nxt = cookie_r;
    tidu_nxt   = tidu_r;
    tidl_nxt   = tidl_r;
    nhp_nxt    = nhp_r;
    alc_nxt    = alc_r;
    lve_nxt    = lve_r;
    cnt_nxt    = cnt_r;
    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 17'd1;
      if (pos_r < 17'd2) begin
        type_nxt = {type_r[7:0], b};
      end else if (pos_r < 17'd4) begin
        len_nxt = {len_r[7:0], b};
      end else if (pos_r < 17'd8) begin
        cookie_nxt = {cookie_r[23:0], b};
      end else if (pos_r < 17'd12) begin
        tidu_nxt = {tidu_r[23:0], b};
      end else if (pos_r < HEADER_BYTES) begin
        tidl_nxt = {tidl_r[55:0], b};
      end else if (pos_ext == hdr2) begin
        alc_nxt = {b, 8'h00};
      end else if (pos_ext == hdr3) begin
        alc_nxt = attr_len;
        lve_nxt = nhp_r + 18'd4 + {2'b00, attr_len};
        nhp_nxt = nhp_r + 18'd4 + {1'b0, padded};
        if (cnt_r != COUNT_MAX) begin
          cnt_nxt = cnt_r + 14'd1;
        end
      end
    end
  end

  assign size_need = HEADER_BYTES + {1'b0, len_nxt};

  always_comb begin
    if (pos_nxt < HEADER_BYTES) begin
      verdict = ERR_SHORT;
    end else if (type_nxt[15:14] != 2'b00) begin
      verdict = ERR_START_BITS;
    end else if (cookie_nxt != MAGIC_COOKIE) begin
      verdict = ERR_MAGIC;
    end else if (len_nxt[1:0] != 2'b00) begin
      verdict = ERR_UNALIGNED;
    end else if (pos_nxt != size_need) begin
      verdict = ERR_SIZE;
    end else if ((type_nxt & ~CLASS_BITS) != METHOD_BINDING) begin
      verdict = ERR_METHOD;
    end else if (lve_nxt > {1'b0, pos_nxt}) begin
      verdict = ERR_OVERRUN;
    end else begin
      verdict = ERR_OK;
    end
  end

  always_comb begin
    res.error_code          = verdict;
    res.message_type        = type_nxt;
    res.message_class       = {type_nxt[8], type_nxt[4]};
    res.response_flag       = type_nxt[8];
    res.msg_length          = len_nxt;
    res.transaction_id_high = tidu_nxt;
    res.transaction_id_low  = tidl_nxt;
    res.attribute_count     = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (st_take && st_item.last)) begin
      pos_r    <= '0;
      type_r   <= '0;
      len_r    <= '0;
      cookie_r <= '0;
      tidu_r   <= '0;
      tidl_r   <= '0;
      nhp_r    <= FIRST_ATTR_POS;
      alc_r    <= '0;
      lve_r    <= '0;
      cnt_r    <= '0;
    end else if (st_take) begin
      pos_r    <= pos_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      cookie_r <= cookie_nxt;
      tidu_r   <= tidu_nxt;
      tidl_r   <= tidl_nxt;
      nhp_r    <= nhp_nxt;
      alc_r    <= alc_nxt;
      lve_r    <= lve_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/smv_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_out_reg
// Result register that holds one verdict until the sink takes it.
// ----------------------------------------------------------------------------
module smv_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  smv_pkg::result_t res,
  output logic             res_free,
  output logic             out_valid,
  input  logic             out_ready,
  output smv_pkg::result_t out_res
);
  import smv_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign res_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

### hdl/stun_message_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_message_validator
// Parses a stun datagram one byte a word and gives one verdict per datagram.
// ----------------------------------------------------------------------------
// the in_tlast word is registered in smv_in_reg, and its verdict is then registered in smv_out_reg
// throughput: one byte per cycle, set by the combinational header walk
// a waiting verdict stalls input only when the next datagram ends
// reset clears the walk state and both valid registers, no output pending
module stun_message_validator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [smv_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // end_of_datagram
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [smv_pkg::OUT_TDATA_W-1:0]  out_tdata   // [2:0] error_code,
                                  // [18:3] message_type,
                                  // [20:19] message_class, [21] response_flag,
                                  // [37:22] msg_length,
                                  // [69:38] transaction_id_high,
                                  // [133:70] transaction_id_low,
                                  // [147:134] attribute_count, [151:148] zero
);
  import smv_pkg::*;

  item_t   in_item;
  item_t   st_item;
  logic    st_valid;
  logic    st_take;
  logic    res_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.data_byte = in_tdata;
  assign in_item.last      = in_tlast;

  smv_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .st_valid (st_valid),
    .st_take  (st_take),
    .st_item  (st_item)
  );

  smv_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_valid  (st_valid),
    .st_item   (st_item),
    .st_take   (st_take),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  smv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0000,
                      out_res.attribute_count,
                      out_res.transaction_id_low,
                      out_res.transaction_id_high,
                      out_res.msg_length,
                      out_res.response_flag,
                      out_res.message_class,
                      out_res.message_type,
                      out_res.error_code};

endmodule

### hdl/smv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_checker
// Port-level checks for the stun message validator, bound to the top level.
// ----------------------------------------------------------------------------
module smv_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [7:0]   in_tdata,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata
);
  import smv_pkg::*;

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("verdict present after reset");

  // class and response flag follow the type bits
  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21] == out_tdata[11] && out_tdata[20] == out_tdata[11]
                   && out_tdata[19] == out_tdata[7] && out_tdata[151:148] == 4'h0)
    else $error("class bits disagree with message type");

  // an accepted message has clean start bits and aligned length
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ERR_OK |->
      out_tdata[18:17] == 2'b00 && out_tdata[23:22] == 2'b00
      && out_tdata[18:3] != 16'h0000)
    else $error("ok verdict with malformed header");

endmodule

bind stun_message_validator smv_checker u_smv_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stun message validator. Datagrams are streamed
// one byte a word: short ones, each header fault, every message class, the
// attribute walk corners, then random well-formed, faulty and noise traffic.
// A bench-side model of the header capture and attribute walk predicts each
// verdict word, and every output word is compared field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import smv_pkg::*;

  localparam int          CLK_PERIOD     = 8;
  localparam int          IDLE_LIMIT     = 2000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [15:0] RESPONSE_BIT   = 16'h0100;
  localparam logic [15:0] INDICATION_BIT = 16'h0010;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;

  stun_message_validator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // parser model state
  logic [POS_W-1:0]   byte_pos;
  logic [15:0]        type_field;
  logic [15:0]        length_field;
  logic [31:0]        cookie_field;
  logic [31:0]        tid_high;
  logic [63:0]        tid_low;
  logic [HDR_W-1:0]   attr_hdr_pos;
  logic [15:0]        attr_len;
  logic [HDR_W-1:0]   value_end;
  logic [COUNT_W-1:0] attr_count;

  result_t     verdict_q[$];
  logic [7:0]  dgram[$];
  int          last_attr_at;
  int          fail_count   = 0;
  int          idle_cycles  = 0;
  int          stall_left   = 0;
  bit          in_idle_en   = 1'b1;
  bit          out_stall_en = 1'b1;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic void clear_parser();
    byte_pos     = '0;
    type_field   = '0;
    length_field = '0;
    cookie_field = '0;
    tid_high     = '0;
    tid_low      = '0;
    attr_hdr_pos = FIRST_ATTR_POS;
    attr_len     = '0;
    value_end    = '0;
    attr_count   = '0;
  endfunction

  function automatic void add_byte(input logic [7:0] v);
    dgram.insert(dgram.size(), v);
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic l);
    int unsigned p;
    int unsigned len;
    int unsigned size;
    result_t     r;
    p = byte_pos;
    if (byte_pos < POS_MAX) begin
      if (p < 2) type_field = {type_field[7:0], b};
      else if (p < 4) length_field = {length_field[7:0], b};
      else if (p < 8) cookie_field = {cookie_field[23:0], b};
      else if (p < 12) tid_high = {tid_high[23:0], b};
      else if (p < HEADER_BYTES) tid_low = {tid_low[55:0], b};
      else if (p == attr_hdr_pos + 2) attr_len = {b, 8'h00};
      else if (p == attr_hdr_pos + 3) begin
        len = {attr_len[15:8], b};
        attr_len = 16'(len);
        value_end = HDR_W'(attr_hdr_pos + 4 + len);
        attr_hdr_pos = HDR_W'(attr_hdr_pos + 4 + ((len + 3) & ~32'd3));
        if (attr_count < COUNT_MAX) attr_count = attr_count + 1'b1;
      end
      byte_pos = byte_pos + 1'b1;
    end
    if (l) begin
      size = byte_pos;
      if (size < HEADER_BYTES) r.error_code = ERR_SHORT;
      else if (type_field[15:14] != 2'b00) r.error_code = ERR_START_BITS;
      else if (cookie_field != MAGIC_COOKIE) r.error_code = ERR_MAGIC;
      else if (length_field[1:0] != 2'b00) r.error_code = ERR_UNALIGNED;
      else if (size != HEADER_BYTES + length_field) r.error_code = ERR_SIZE;
      else if ((type_field & ~CLASS_BITS) != METHOD_BINDING) r.error_code = ERR_METHOD;
      else if (value_end > size) r.error_code = ERR_OVERRUN;
      else r.error_code = ERR_OK;
      r.message_type        = type_field;
      r.message_class       = {type_field[8], type_field[4]};
      r.response_flag       = type_field[8];
      r.msg_length          = length_field;
      r.transaction_id_high = tid_high;
      r.transaction_id_low  = tid_low;
      r.attribute_count     = attr_count;
      verdict_q.insert(verdict_q.size(), r);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------- driving
  task automatic send_word(input logic [7:0] b, input logic l);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, l);
    @(negedge clk);
  endtask

  task automatic send_dgram();
    foreach (dgram[i]) send_word(dgram[i], i == dgram.size() - 1);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (out_stall_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ------------------------------------------------------------- datagrams
  task automatic push_header(input logic [15:0] mtype, input logic [15:0] len);
    add_byte(mtype[15:8]);
    add_byte(mtype[7:0]);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    for (int i = 3; i >= 0; i--) add_byte(MAGIC_COOKIE[8*i +: 8]);
    repeat (12) add_byte(8'($urandom));
  endtask

  task automatic set_length_field(input logic [15:0] len);
    dgram[2] = len[15:8];
    dgram[3] = len[7:0];
  endtask

  task automatic build_message(input logic [15:0] mtype, input int n_attr,
                               input int max_val);
    logic [7:0] payload[$];
    int         vlen;
    dgram.delete();
    last_attr_at = -1;
    for (int i = 0; i < n_attr; i++) begin
      last_attr_at = HEADER_BYTES + payload.size();
      vlen = $urandom_range(0, max_val);
      payload.insert(payload.size(), 8'($urandom));
      payload.insert(payload.size(), 8'($urandom));
      payload.insert(payload.size(), 8'(vlen >> 8));
      payload.insert(payload.size(), 8'(vlen));
      repeat ((vlen + 3) & ~3) payload.insert(payload.size(), 8'($urandom));
    end
    push_header(mtype, 16'(payload.size()));
    foreach (payload[i]) add_byte(payload[i]);
  endtask

  function automatic logic [15:0] random_binding_type();
    return METHOD_BINDING | (16'($urandom) & CLASS_BITS);
  endfunction

  task automatic apply_fault(input err_t kind);
    logic [15:0] val;
    int          target;
    case (kind)
      ERR_SHORT: begin
        target = $urandom_range(1, HEADER_BYTES - 1);
        while (dgram.size() > target) void'(dgram.pop_back());
      end
      ERR_START_BITS: begin
        dgram[0][7:6] = 2'($urandom_range(1, 3));
      end
      ERR_MAGIC: begin
        target = $urandom_range(4, 7);
        dgram[target] = dgram[target] ^ (8'h01 << $urandom_range(0, 7));
      end
      ERR_UNALIGNED: begin
        val = {dgram[2], dgram[3]};
        set_length_field(val + 16'($urandom_range(1, 3)));
      end
      ERR_SIZE: begin
        if (dgram.size() > HEADER_BYTES && $urandom_range(0, 1) == 1) begin
          target = dgram.size() - $urandom_range(1, dgram.size() - HEADER_BYTES);
          while (dgram.size() > target) void'(dgram.pop_back());
        end else begin
          repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
        end
      end
      ERR_METHOD: begin
        val = {2'b00, 14'($urandom)};
        if ((val & ~CLASS_BITS) == METHOD_BINDING) val = val ^ 16'h0002;
        dgram[0] = val[15:8];
        dgram[1] = val[7:0];
      end
      ERR_OVERRUN: begin
        if (last_attr_at >= 0) begin
          val = 16'(dgram.size() - last_attr_at - 4 + $urandom_range(1, 200));
          dgram[last_attr_at + 2] = val[15:8];
          dgram[last_attr_at + 3] = val[7:0];
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------- checking
  task automatic report_fault(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) report_fault(what, want, got);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.error_code          = err_t'(out_tdata[2:0]);
      got.message_type        = out_tdata[18:3];
      got.message_class       = out_tdata[20:19];
      got.response_flag       = out_tdata[21];
      got.msg_length          = out_tdata[37:22];
      got.transaction_id_high = out_tdata[69:38];
      got.transaction_id_low  = out_tdata[133:70];
      got.attribute_count     = out_tdata[147:134];
      if (verdict_q.size() == 0) begin
        report_fault("unexpected word, error_code", '0, got.error_code);
      end else begin
        want = verdict_q.pop_front();
        check_field("error_code", want.error_code, got.error_code);
        check_field("message_type", want.message_type, got.message_type);
        check_field("message_class", want.message_class, got.message_class);
        check_field("response_flag", want.response_flag, got.response_flag);
        check_field("msg_length", want.msg_length, got.msg_length);
        check_field("transaction_id_high", want.transaction_id_high,
                    got.transaction_id_high);
        check_field("transaction_id_low", want.transaction_id_low,
                    got.transaction_id_low);
        check_field("attribute_count", want.attribute_count, got.attribute_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------ tests
  task automatic test_short_datagrams();
    dgram.delete();
    add_byte(8'hFF);
    send_dgram();
    build_message(METHOD_BINDING, 0, 0);
    void'(dgram.pop_back());
    send_dgram();
    build_message(METHOD_BINDING, 0, 0);
    apply_fault(ERR_SHORT);
    send_dgram();
    build_message(METHOD_BINDING, 0, 0);
    send_dgram();
  endtask

  task automatic test_header_checks();
    for (int k = ERR_START_BITS; k <= ERR_OVERRUN; k++) begin
      build_message(METHOD_BINDING, 2, 4);
      apply_fault(err_t'(k));
      send_dgram();
    end
    // attribute length at its maximum
    build_message(METHOD_BINDING, 1, 4);
    dgram[last_attr_at + 2] = 8'hFF;
    dgram[last_attr_at + 3] = 8'hFF;
    send_dgram();
  endtask

  task automatic test_message_classes();
    for (int c = 0; c < 4; c++) begin
      build_message(METHOD_BINDING | (c[1] ? RESPONSE_BIT : 16'h0) |
                    (c[0] ? INDICATION_BIT : 16'h0), 1, 8);
      send_dgram();
    end
  endtask

  task automatic test_attribute_walk();
    dgram.delete();
    repeat (28) add_byte(8'hFF);
    send_dgram();
    dgram.delete();
    repeat (HEADER_BYTES) add_byte(8'h00);
    send_dgram();
    // partial attribute header at the end
    dgram.delete();
    push_header(METHOD_BINDING, 16'd4);
    add_byte(8'h80);
    add_byte(8'h22);
    send_dgram();
    build_message(METHOD_BINDING, 6, 0);
    send_dgram();
  endtask

  task automatic test_random_traffic(input int min_bytes, input int min_dgrams);
    int sent_bytes;
    int sent_dgrams;
    int pick;
    sent_bytes  = 0;
    sent_dgrams = 0;
    while (sent_bytes < min_bytes || sent_dgrams < min_dgrams) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        dgram.delete();
        repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
      end else begin
        build_message(random_binding_type(), $urandom_range(0, 4),
                      ($urandom_range(0, 3) == 0) ? 40 : 12);
        if (pick >= 60) apply_fault(err_t'($urandom_range(ERR_SHORT, ERR_OVERRUN)));
      end
      send_dgram();
      sent_bytes += dgram.size();
      sent_dgrams++;
    end
  endtask

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_short_datagrams();
    test_header_checks();
    test_message_classes();
    test_attribute_walk();
    test_random_traffic(80, 4);
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    test_random_traffic(40, 3);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
hdl/smv_pkg.sv
hdl/smv_in_reg.sv
hdl/smv_walk.sv
hdl/smv_out_reg.sv
hdl/stun_message_validator.sv
hdl/smv_checker.sv
tb/tb.sv
